// ----- src/bsm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared constant for the bounding sphere merge pipeline.
// ----------------------------------------------------------------------------
package bsm_pkg;

   // Default width of a center coordinate; radii are one bit narrower.
   localparam int DEF_COORD_WIDTH = 32;

endpackage
`default_nettype wire

// ----- src/bsm_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_if
// Valid/ready channels for sphere pairs in and merged spheres out.
// ----------------------------------------------------------------------------
interface bsm_req_if
   import bsm_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
);
   logic                   valid;
   logic                   ready;
   logic [COORD_WIDTH-1:0] a_center_x;
   logic [COORD_WIDTH-1:0] a_center_y;
   logic [COORD_WIDTH-1:0] a_center_z;
   logic [COORD_WIDTH-2:0] a_radius;
   logic [COORD_WIDTH-1:0] b_center_x;
   logic [COORD_WIDTH-1:0] b_center_y;
   logic [COORD_WIDTH-1:0] b_center_z;
   logic [COORD_WIDTH-2:0] b_radius;

   modport source (output valid, a_center_x, a_center_y, a_center_z, a_radius,
                   b_center_x, b_center_y, b_center_z, b_radius, input ready);
   modport sink   (input valid, a_center_x, a_center_y, a_center_z, a_radius,
                   b_center_x, b_center_y, b_center_z, b_radius, output ready);
endinterface

interface bsm_rsp_if
   import bsm_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
);
   logic                     valid;
   logic                     ready;
   logic [COORD_WIDTH-1:0]   merged_x;
   logic [COORD_WIDTH-1:0]   merged_y;
   logic [COORD_WIDTH-1:0]   merged_z;
   logic [COORD_WIDTH-2:0]   merged_radius;
   logic [2*COORD_WIDTH-2:0] growth;
   logic                     overlap;
   logic                     enclosed;

   modport source (output valid, merged_x, merged_y, merged_z, merged_radius, growth,
                   overlap, enclosed, input ready);
   modport sink   (input valid, merged_x, merged_y, merged_z, merged_radius, growth,
                   overlap, enclosed, output ready);
endinterface
`default_nettype wire

// ----- src/bsm_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_sqrt
// Pipelined integer square root, one root bit per stage (floor of the root).
// ----------------------------------------------------------------------------
module bsm_sqrt
   import bsm_pkg::*;
#(
   parameter int VAL_WIDTH = 2 * DEF_COORD_WIDTH + 4,
   parameter int TAG_WIDTH = 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     enable,
   input  wire logic                     in_valid,
   input  wire logic [VAL_WIDTH-1:0]     in_val,
   input  wire logic [TAG_WIDTH-1:0]     in_tag,
   output logic                          out_valid,
   output logic [VAL_WIDTH/2-1:0]        out_root,
   output logic [TAG_WIDTH-1:0]          out_tag
);
   localparam int RW = VAL_WIDTH / 2;
   localparam int EW = RW + 2;

   logic                 vld_ff  [RW];
   logic [VAL_WIDTH-1:0] val_ff  [RW];
   logic [RW-1:0]        root_ff [RW];
   logic [EW-1:0]        rem_ff  [RW];
   logic [TAG_WIDTH-1:0] tag_ff  [RW];
   logic                 vld_in  [RW];
   logic [VAL_WIDTH-1:0] val_in  [RW];
   logic [RW-1:0]        root_in [RW];
   logic [EW-1:0]        rem_in  [RW];
   logic [TAG_WIDTH-1:0] tag_in  [RW];

   always_comb begin
      logic                 vld_s;
      logic [VAL_WIDTH-1:0] val_s;
      logic [RW-1:0]        root_s;
      logic [EW-1:0]        rem_s;
      logic [TAG_WIDTH-1:0] tag_s;
      logic [EW+1:0]        sh;
      logic [EW+1:0]        trial;
      for (int k = 0; k < RW; k++) begin
         if (k == 0) begin
            vld_s  = in_valid;
            val_s  = in_val;
            root_s = '0;
            rem_s  = '0;
            tag_s  = in_tag;
         end else begin
            vld_s  = vld_ff[k-1];
            val_s  = val_ff[k-1];
            root_s = root_ff[k-1];
            rem_s  = rem_ff[k-1];
            tag_s  = tag_ff[k-1];
         end
         // Bring down the next pair of radicand bits and try root*4+1.
         sh    = {rem_s, val_s[VAL_WIDTH-1 -: 2]};
         trial = (EW+2)'({root_s, 2'b01});
         if (sh >= trial) begin
            rem_in[k]  = EW'(sh - trial);
            root_in[k] = {root_s[RW-2:0], 1'b1};
         end else begin
            rem_in[k]  = sh[EW-1:0];
            root_in[k] = {root_s[RW-2:0], 1'b0};
         end
         val_in[k] = val_s << 2;
         vld_in[k] = vld_s;
         tag_in[k] = tag_s;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < RW; k++) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (enable) begin
            vld_ff[k] <= vld_in[k];
         end
         if (enable) begin
            val_ff[k]  <= val_in[k];
            root_ff[k] <= root_in[k];
            rem_ff[k]  <= rem_in[k];
            tag_ff[k]  <= tag_in[k];
         end
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_tag   = tag_ff[RW-1];

endmodule
`default_nettype wire

// ----- src/bsm_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_div
// Pipelined restoring divider, several lanes sharing one divisor.
// ----------------------------------------------------------------------------
module bsm_div
   import bsm_pkg::*;
#(
   parameter int NUM_WIDTH = 2 * DEF_COORD_WIDTH + 3,
   parameter int DEN_WIDTH = DEF_COORD_WIDTH + 2,
   parameter int QUO_WIDTH = DEF_COORD_WIDTH + 2,
   parameter int LANES     = 3,
   parameter int TAG_WIDTH = 1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              enable,
   input  wire logic                              in_valid,
   input  wire logic [LANES-1:0][NUM_WIDTH-1:0]   in_num,
   input  wire logic [DEN_WIDTH-1:0]              in_den,
   input  wire logic [TAG_WIDTH-1:0]              in_tag,
   output logic                                   out_valid,
   output logic [LANES-1:0][QUO_WIDTH-1:0]        out_quo,
   output logic [TAG_WIDTH-1:0]                   out_tag
);
   // The quotient is known to fit QUO_WIDTH bits, so the numerator bits above
   // the quotient start out as a partial remainder below the divisor.
   logic                               vld_ff [QUO_WIDTH];
   logic [LANES-1:0][DEN_WIDTH-1:0]    rem_ff [QUO_WIDTH];
   logic [LANES-1:0][QUO_WIDTH-1:0]    lo_ff  [QUO_WIDTH];
   logic [LANES-1:0][QUO_WIDTH-1:0]    quo_ff [QUO_WIDTH];
   logic [DEN_WIDTH-1:0]               den_ff [QUO_WIDTH];
   logic [TAG_WIDTH-1:0]               tag_ff [QUO_WIDTH];
   logic                               vld_in [QUO_WIDTH];
   logic [LANES-1:0][DEN_WIDTH-1:0]    rem_in [QUO_WIDTH];
   logic [LANES-1:0][QUO_WIDTH-1:0]    lo_in  [QUO_WIDTH];
   logic [LANES-1:0][QUO_WIDTH-1:0]    quo_in [QUO_WIDTH];
   logic [DEN_WIDTH-1:0]               den_in [QUO_WIDTH];
   logic [TAG_WIDTH-1:0]               tag_in [QUO_WIDTH];

   always_comb begin
      logic                            vld_s;
      logic [LANES-1:0][DEN_WIDTH-1:0] rem_s;
      logic [LANES-1:0][QUO_WIDTH-1:0] lo_s;
      logic [LANES-1:0][QUO_WIDTH-1:0] quo_s;
      logic [DEN_WIDTH-1:0]            den_s;
      logic [TAG_WIDTH-1:0]            tag_s;
      logic [DEN_WIDTH:0]              sh;
      for (int k = 0; k < QUO_WIDTH; k++) begin
         if (k == 0) begin
            vld_s = in_valid;
            den_s = in_den;
            tag_s = in_tag;
            quo_s = '0;
            for (int l = 0; l < LANES; l++) begin
               rem_s[l] = DEN_WIDTH'(in_num[l] >> QUO_WIDTH);
               lo_s[l]  = in_num[l][QUO_WIDTH-1:0];
            end
         end else begin
            vld_s = vld_ff[k-1];
            den_s = den_ff[k-1];
            tag_s = tag_ff[k-1];
            quo_s = quo_ff[k-1];
            rem_s = rem_ff[k-1];
            lo_s  = lo_ff[k-1];
         end
         for (int l = 0; l < LANES; l++) begin
            sh = {rem_s[l], lo_s[l][QUO_WIDTH-1]};
            if (sh >= {1'b0, den_s}) begin
               rem_in[k][l] = DEN_WIDTH'(sh - {1'b0, den_s});
               quo_in[k][l] = {quo_s[l][QUO_WIDTH-2:0], 1'b1};
            end else begin
               rem_in[k][l] = sh[DEN_WIDTH-1:0];
               quo_in[k][l] = {quo_s[l][QUO_WIDTH-2:0], 1'b0};
            end
            lo_in[k][l] = lo_s[l] << 1;
         end
         vld_in[k] = vld_s;
         den_in[k] = den_s;
         tag_in[k] = tag_s;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QUO_WIDTH; k++) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (enable) begin
            vld_ff[k] <= vld_in[k];
         end
         if (enable) begin
            rem_ff[k] <= rem_in[k];
            lo_ff[k]  <= lo_in[k];
            quo_ff[k] <= quo_in[k];
            den_ff[k] <= den_in[k];
            tag_ff[k] <= tag_in[k];
         end
      end
   end

   assign out_valid = vld_ff[QUO_WIDTH-1];
   assign out_quo   = quo_ff[QUO_WIDTH-1];
   assign out_tag   = tag_ff[QUO_WIDTH-1];

endmodule
`default_nettype wire

// ----- src/bounding_sphere_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipeline from an accepted request word to its response word: four setup
// stages, one stage per root bit in the square root, two stages, one stage per
// quotient bit in the divider, three output stages. Throughput: one word per
// cycle; the whole pipeline advances together and holds while the output
// register is full and not taken.
// Reset clears every stage valid bit; no data is cleared.
// ----------------------------------------------------------------------------
// bounding_sphere_merge
// Smallest sphere enclosing two spheres, with overlap flag and radius growth.
// ----------------------------------------------------------------------------
module bounding_sphere_merge
   import bsm_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
   input  wire logic  clock,
   input  wire logic  reset,
   bsm_req_if.sink    req_ch,
   bsm_rsp_if.source  rsp_ch
);
   localparam int CW  = COORD_WIDTH;
   localparam int MW  = CW + 1;          // center delta / magnitude
   localparam int SQW = 2 * MW + 2;      // squared distance
   localparam int RTW = SQW / 2;         // distance
   localparam int NW  = RTW;             // full radius and offset numerator
   localparam int PW  = MW + NW;         // delta times numerator
   localparam int SW  = NW + 2;          // center plus offset

   typedef struct packed {
      logic [2:0][CW-1:0] ac;
      logic [2:0][MW-1:0] dl;
      logic [2:0][MW-1:0] mg;
      logic [CW-2:0]      ra;
      logic [CW-2:0]      rb;
      logic [CW-1:0]      rs;
      logic [NW-1:0]      rfull;
      logic               enc;
      logic               ovl;
   } side_type;

   localparam int TW = $bits(side_type);

   logic adv;
   assign adv          = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = adv;

   // Stage 1: center deltas and radius sum and difference.
   logic               v1_ff;
   side_type           sd1_ff, sd1_in;
   logic [CW-2:0]      rd1_ff, rd1_in;

   always_comb begin
      logic [2:0][CW-1:0] bc;
      sd1_in       = '0;
      sd1_in.ac[0] = req_ch.a_center_x;
      sd1_in.ac[1] = req_ch.a_center_y;
      sd1_in.ac[2] = req_ch.a_center_z;
      bc[0]        = req_ch.b_center_x;
      bc[1]        = req_ch.b_center_y;
      bc[2]        = req_ch.b_center_z;
      for (int i = 0; i < 3; i++) begin
         sd1_in.dl[i] = {bc[i][CW-1], bc[i]} - {sd1_in.ac[i][CW-1], sd1_in.ac[i]};
         sd1_in.mg[i] = sd1_in.dl[i][MW-1] ? MW'(-sd1_in.dl[i]) : sd1_in.dl[i];
      end
      sd1_in.ra = req_ch.a_radius;
      sd1_in.rb = req_ch.b_radius;
      sd1_in.rs = {1'b0, req_ch.a_radius} + {1'b0, req_ch.b_radius};
      rd1_in    = (req_ch.a_radius > req_ch.b_radius) ?
                  req_ch.a_radius - req_ch.b_radius : req_ch.b_radius - req_ch.a_radius;
   end

   // Stage 2: squares.
   logic                 v2_ff;
   side_type             sd2_ff;
   logic [2:0][2*MW-1:0] sq2_ff;
   logic [2*CW-3:0]      rd2_ff;
   logic [2*CW-1:0]      rs2_ff;

   // Stage 3: squared distance.
   logic            v3_ff;
   side_type        sd3_ff;
   logic [SQW-1:0]  d2_3_ff;
   logic [2*CW-3:0] rd3_ff;
   logic [2*CW-1:0] rs3_ff;

   // Stage 4: containment and overlap tests.
   logic           v4_ff;
   side_type       sd4_ff, sd4_in;
   logic [SQW-1:0] d2_4_ff;

   always_comb begin
      sd4_in     = sd3_ff;
      sd4_in.enc = SQW'(rd3_ff) >= d2_3_ff;
      sd4_in.ovl = d2_3_ff < SQW'(rs3_ff);
   end

   // Square root of the squared distance.
   logic           vq;
   logic [RTW-1:0] dq;
   logic [TW-1:0]  tq;
   side_type       sdq;

   bsm_sqrt #(
      .VAL_WIDTH (SQW),
      .TAG_WIDTH (TW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (v4_ff),
      .in_val    (d2_4_ff),
      .in_tag    (sd4_ff),
      .out_valid (vq),
      .out_root  (dq),
      .out_tag   (tq)
   );
   assign sdq = side_type'(tq);

   // Stage 5: full merged radius and the offset numerator.
   logic           v5_ff;
   side_type       sd5_ff, sd5_in;
   logic [NW-1:0]  num5_ff, num5_in;
   logic [RTW-1:0] d5_ff;

   always_comb begin
      logic [RTW:0] tot;
      tot          = {1'b0, dq} + (RTW+1)'(sdq.rs);
      sd5_in       = sdq;
      sd5_in.rfull = tot[RTW:1];
      num5_in      = sd5_in.rfull - NW'(sdq.ra);
   end

   // Stage 6: delta magnitude times numerator.
   logic               v6_ff;
   side_type           sd6_ff;
   logic [2:0][PW-1:0] prod6_ff;
   logic [RTW-1:0]     d6_ff;

   logic               vdv;
   logic [2:0][NW-1:0] quo;
   logic [TW-1:0]      tdv;
   side_type           sdv;

   bsm_div #(
      .NUM_WIDTH (PW),
      .DEN_WIDTH (RTW),
      .QUO_WIDTH (NW),
      .LANES     (3),
      .TAG_WIDTH (TW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (v6_ff),
      .in_num    (prod6_ff),
      .in_den    (d6_ff),
      .in_tag    (sd6_ff),
      .out_valid (vdv),
      .out_quo   (quo),
      .out_tag   (tdv)
   );
   assign sdv = side_type'(tdv);

   // Stage 7: merged center with clamping, merged radius.
   logic               v7_ff;
   logic [2:0][CW-1:0] mc7_ff, mc7_in;
   logic [CW-2:0]      mr7_ff, mr7_in;
   logic [CW-2:0]      ra7_ff;
   logic               enc7_ff, ovl7_ff;

   always_comb begin
      logic          pick_a;
      logic [SW-1:0] c;
      logic [SW-1:0] ax;
      pick_a = sdv.ra > sdv.rb;
      for (int i = 0; i < 3; i++) begin
         ax = {{(SW-CW){sdv.ac[i][CW-1]}}, sdv.ac[i]};
         c  = sdv.dl[i][MW-1] ? ax - SW'(quo[i]) : ax + SW'(quo[i]);
         if (sdv.enc) begin
            mc7_in[i] = pick_a ? sdv.ac[i] : sdv.ac[i] + sdv.dl[i][CW-1:0];
         end else if (c[SW-1:CW-1] == {(SW-CW+1){c[SW-1]}}) begin
            mc7_in[i] = c[CW-1:0];
         end else if (c[SW-1]) begin
            mc7_in[i] = {1'b1, {(CW-1){1'b0}}};
         end else begin
            mc7_in[i] = {1'b0, {(CW-1){1'b1}}};
         end
      end
      if (sdv.enc) begin
         mr7_in = pick_a ? sdv.ra : sdv.rb;
      end else if (sdv.rfull > NW'({(CW-1){1'b1}})) begin
         mr7_in = {(CW-1){1'b1}};
      end else begin
         mr7_in = sdv.rfull[CW-2:0];
      end
   end

   // Stage 8: squared radii.
   logic               v8_ff;
   logic [2:0][CW-1:0] mc8_ff;
   logic [CW-2:0]      mr8_ff;
   logic [2*CW-3:0]    m2_8_ff, a2_8_ff;
   logic               enc8_ff, ovl8_ff;

   // Stage 9: output register.
   logic                 v9_ff;
   logic [2:0][CW-1:0]   mc9_ff;
   logic [CW-2:0]        mr9_ff;
   logic [2*CW-2:0]      gr9_ff;
   logic                 enc9_ff, ovl9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_ch.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= vq;
         v6_ff <= v5_ff;
         v7_ff <= vdv;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sd1_ff <= sd1_in;
         rd1_ff <= rd1_in;

         sd2_ff <= sd1_ff;
         for (int i = 0; i < 3; i++) begin
            sq2_ff[i] <= sd1_ff.mg[i] * sd1_ff.mg[i];
         end
         rd2_ff <= rd1_ff * rd1_ff;
         rs2_ff <= sd1_ff.rs * sd1_ff.rs;

         sd3_ff  <= sd2_ff;
         d2_3_ff <= SQW'(sq2_ff[0]) + SQW'(sq2_ff[1]) + SQW'(sq2_ff[2]);
         rd3_ff  <= rd2_ff;
         rs3_ff  <= rs2_ff;

         sd4_ff  <= sd4_in;
         d2_4_ff <= d2_3_ff;

         sd5_ff  <= sd5_in;
         num5_ff <= num5_in;
         d5_ff   <= dq;

         sd6_ff <= sd5_ff;
         for (int i = 0; i < 3; i++) begin
            prod6_ff[i] <= sd5_ff.mg[i] * num5_ff;
         end
         d6_ff <= d5_ff;

         mc7_ff  <= mc7_in;
         mr7_ff  <= mr7_in;
         ra7_ff  <= sdv.ra;
         enc7_ff <= sdv.enc;
         ovl7_ff <= sdv.ovl;

         mc8_ff  <= mc7_ff;
         mr8_ff  <= mr7_ff;
         m2_8_ff <= mr7_ff * mr7_ff;
         a2_8_ff <= ra7_ff * ra7_ff;
         enc8_ff <= enc7_ff;
         ovl8_ff <= ovl7_ff;

         mc9_ff  <= mc8_ff;
         mr9_ff  <= mr8_ff;
         gr9_ff  <= (m2_8_ff > a2_8_ff) ? (2*CW-1)'(m2_8_ff - a2_8_ff) : '0;
         enc9_ff <= enc8_ff;
         ovl9_ff <= ovl8_ff;
      end
   end

   assign rsp_ch.valid         = v9_ff;
   assign rsp_ch.merged_x      = mc9_ff[0];
   assign rsp_ch.merged_y      = mc9_ff[1];
   assign rsp_ch.merged_z      = mc9_ff[2];
   assign rsp_ch.merged_radius = mr9_ff;
   assign rsp_ch.growth        = gr9_ff;
   assign rsp_ch.overlap       = ovl9_ff;
   assign rsp_ch.enclosed      = enc9_ff;

   // A stall must freeze every stage, including the ones inside the units.
   assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v4_ff) && $stable(vq) && $stable(vdv) && $stable(v7_ff))
      else $error("pipeline moved during a stall");

   // Outside containment the distance is at least one, so the divider is safe.
   assert property (@(posedge clock) disable iff (reset)
      v5_ff && !sd5_ff.enc |-> d5_ff != '0)
      else $error("zero distance reached the divider");

   // Outside containment the full radius never falls below the first radius.
   assert property (@(posedge clock) disable iff (reset)
      v5_ff && !sd5_ff.enc |-> num5_ff <= sd5_ff.rfull)
      else $error("offset numerator underflow");

   assert property (@(posedge clock) disable iff (reset)
      v7_ff && !enc7_ff |-> mr7_ff >= ra7_ff)
      else $error("merged radius below first radius");

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks bounding_sphere_merge against a bit-exact model of the sphere union.
// A short table of directed pairs is followed by random pairs; each accepted
// request word is predicted and each response word is compared in order, with
// random idling on both channels and one long hold-off on the response side.
// ----------------------------------------------------------------------------
module tb
   import bsm_pkg::*;
();

   localparam int CW = DEF_COORD_WIDTH;
   localparam int N_RANDOM = 640;
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 120;
   localparam logic [CW-2:0] RAD_MAX = {(CW-1){1'b1}};
   localparam logic signed [63:0] C_MAX = 64'sd2147483647;
   localparam logic signed [63:0] C_MIN = -64'sd2147483648;

   typedef struct packed {
      logic [2:0][CW-1:0] a_c;
      logic [CW-2:0]      a_r;
      logic [2:0][CW-1:0] b_c;
      logic [CW-2:0]      b_r;
   } pair_type;

   typedef struct packed {
      logic [2:0][CW-1:0] m_c;
      logic [CW-2:0]      m_r;
      logic [2*CW-2:0]    growth;
      logic               overlap;
      logic               enclosed;
   } sphere_type;

   typedef struct packed {
      pair_type   pair;
      logic       typed;
      sphere_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bsm_req_if #(.COORD_WIDTH(CW)) req_ch ();
   bsm_rsp_if #(.COORD_WIDTH(CW)) rsp_ch ();

   bounding_sphere_merge #(.COORD_WIDTH(CW)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   sphere_type expected_spheres[$];
   row_type    directed[$];
   int         errors = 0;
   int         sent = 0;
   int         phase = 0;
   int         idle_cycles = 0;
   int         hold_left = 0;
   bit         hold_done = 0;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("tb: mismatch on %s: got %h, want %h", what, got, want);
      errors++;
   endtask

   function automatic logic [63:0] magnitude(input logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic sphere_type merge_spheres(input pair_type p);
      sphere_type s;
      logic signed [63:0] ac[3], bc[3], dl[3], c;
      logic [127:0] d2, t, u;
      logic [63:0] ra, rb, rd, rs, d, rfull, num, off, cand, mr, m2, a2;
      d2 = 0;
      ra = p.a_r;
      rb = p.b_r;
      for (int i = 0; i < 3; i++) begin
         ac[i] = {{32{p.a_c[i][CW-1]}}, p.a_c[i]};
         bc[i] = {{32{p.b_c[i][CW-1]}}, p.b_c[i]};
         dl[i] = bc[i] - ac[i];
         t = magnitude(dl[i]);
         d2 = d2 + t * t;
      end
      rd = ra > rb ? ra - rb : rb - ra;
      rs = ra + rb;
      t = rd;
      u = rs;
      s.enclosed = (t * t) >= d2;
      s.overlap = d2 < (u * u);
      if (s.enclosed) begin
         for (int i = 0; i < 3; i++) s.m_c[i] = ra > rb ? p.a_c[i] : p.b_c[i];
         mr = ra > rb ? ra : rb;
      end else begin
         d = 0;
         for (int b = 35; b >= 0; b--) begin
            cand = d | (64'd1 << b);
            t = cand;
            if (t * t <= d2) d = cand;
         end
         rfull = (d + rs) >> 1;
         num = rfull - ra;
         for (int i = 0; i < 3; i++) begin
            c = ac[i];
            if (d > 0) begin
               t = magnitude(dl[i]);
               t = (t * num) / d;
               off = t[63:0];
               c = dl[i] < 0 ? c - $signed(off) : c + $signed(off);
            end
            if (c > C_MAX) c = C_MAX;
            if (c < C_MIN) c = C_MIN;
            s.m_c[i] = c[CW-1:0];
         end
         mr = rfull > RAD_MAX ? {33'd0, RAD_MAX} : rfull;
      end
      s.m_r = mr[CW-2:0];
      m2 = mr * mr;
      a2 = ra * ra;
      s.growth = m2 > a2 ? m2 - a2 : 0;
      return s;
   endfunction

   function automatic logic [CW-1:0] rand_coord(input int kind);
      case (kind)
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $signed($urandom_range(0, 2097152)) - 1048576;
      endcase
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      int kind;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
         p.a_c[i] = rand_coord(kind < 3 ? 0 : (kind == 3 ? 1 : 2));
         p.b_c[i] = rand_coord(kind < 3 ? 0 : (kind == 3 ? 1 : 2));
      end
      p.a_r = kind < 2 ? 31'($urandom()) : 31'($urandom_range(0, 1 << 21));
      p.b_r = kind < 2 ? 31'($urandom()) : 31'($urandom_range(0, 1 << 21));
      // Shared or nearly shared centers exercise the containment branch.
      if (kind == 8) p.b_c = p.a_c;
      if (kind == 9) begin
         p.b_c = p.a_c;
         p.b_c[0] = p.b_c[0] + $urandom_range(0, 3);
         if ($urandom_range(0, 1)) p.b_r = p.a_r;
      end
      return p;
   endfunction

   function automatic row_type row(input pair_type p, input logic typed, input sphere_type w);
      row_type r;
      r.pair = p;
      r.typed = typed;
      r.want = w;
      return r;
   endfunction

   function automatic pair_type mk(input logic [CW-1:0] ax, ay, az, input logic [CW-2:0] ar,
                                   input logic [CW-1:0] bx, by, bz, input logic [CW-2:0] br);
      pair_type p;
      p.a_c = {az, ay, ax};
      p.a_r = ar;
      p.b_c = {bz, by, bx};
      p.b_r = br;
      return p;
   endfunction

   initial begin
      sphere_type none;
      none = '0;
      directed.push_back(row(mk(0, 0, 0, 0, 0, 0, 0, 0), 1, '{m_c: '0, m_r: 0, growth: 0,
                             overlap: 0, enclosed: 1}));
      directed.push_back(row(mk(0, 0, 0, RAD_MAX, 0, 0, 0, RAD_MAX), 1,
                             '{m_c: '0, m_r: RAD_MAX, growth: 0, overlap: 1, enclosed: 1}));
      directed.push_back(row(mk(32'h50000, 32'h50000, 32'h50000, 31'hA0000,
                                32'h50000, 32'h50000, 32'h50000, 31'h30000), 1,
                             '{m_c: {3{32'h50000}}, m_r: 31'hA0000, growth: 0,
                               overlap: 1, enclosed: 1}));
      // Equal radii, shared center: the second sphere wins the tie.
      directed.push_back(row(mk(1, 2, 3, 7, 1, 2, 3, 7), 0, none));
      // Corners of the coordinate range with maximal radii saturate the radius.
      directed.push_back(row(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, RAD_MAX,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, RAD_MAX), 0, none));
      directed.push_back(row(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                                32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0), 0, none));
      directed.push_back(row(mk(32'h8000_0000, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, RAD_MAX), 0, none));
      // Spheres that just touch do not overlap.
      directed.push_back(row(mk(0, 0, 0, 31'h10000, 32'h30000, 0, 0, 31'h20000), 0, none));
      directed.push_back(row(mk(0, 0, 0, 31'h10000, 32'h2FFFF, 0, 0, 31'h20000), 0, none));
      // Internally tangent: containment holds exactly at the boundary.
      directed.push_back(row(mk(0, 0, 0, 31'h50000, 32'h20000, 0, 0, 31'h30000), 0, none));
      directed.push_back(row(mk(0, 0, 0, 31'h50000, 32'h20001, 0, 0, 31'h30000), 0, none));
      directed.push_back(row(mk(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_FFFF, 31'h1234,
                                32'h0003_0000, 32'hFFF0_0000, 32'h0000_0001, 31'h4321), 0, none));
      directed.push_back(row(mk(5, 5, 5, 0, 6, 5, 5, 0), 0, none));
      directed.push_back(row(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, RAD_MAX,
                                0, 0, 0, 0), 0, none));
   end

   task automatic offer(input pair_type p, input logic typed, input sphere_type want);
      int idle_pct;
      idle_pct = phase == 0 ? 29 : (phase == 1 ? 50 : 0);
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
      end
      @(negedge clock);
      req_ch.valid = 1'b1;
      {req_ch.a_center_z, req_ch.a_center_y, req_ch.a_center_x} = p.a_c;
      req_ch.a_radius = p.a_r;
      {req_ch.b_center_z, req_ch.b_center_y, req_ch.b_center_x} = p.b_c;
      req_ch.b_radius = p.b_r;
      do @(posedge clock); while (!req_ch.ready);
      expected_spheres.push_back(typed ? want : merge_spheres(p));
      sent++;
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.a_center_x = '0;
      req_ch.a_center_y = '0;
      req_ch.a_center_z = '0;
      req_ch.a_radius = '0;
      req_ch.b_center_x = '0;
      req_ch.b_center_y = '0;
      req_ch.b_center_z = '0;
      req_ch.b_radius = '0;
      rsp_ch.ready = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (directed[i]) offer(directed[i].pair, directed[i].typed, directed[i].want);
      for (int i = 0; i < N_RANDOM; i++) begin
         phase = i < N_RANDOM / 3 ? 0 : (i < 2 * N_RANDOM / 3 ? 1 : 2);
         offer(random_pair(), 0, '0);
      end
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (expected_spheres.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

   // Response side: random idling per phase and one long hold-off.
   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && sent >= 150) begin
            hold_done = 1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = $urandom_range(0, 99) >= (phase == 0 ? 50 : (phase == 1 ? 29 : 0));
         end
      end
   end

   always @(posedge clock) begin
      sphere_type w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_spheres.size() == 0) begin
            report("unexpected word", 0, 0);
         end else begin
            w = expected_spheres.pop_front();
            if (rsp_ch.merged_x !== w.m_c[0]) report("merged_x", rsp_ch.merged_x, w.m_c[0]);
            if (rsp_ch.merged_y !== w.m_c[1]) report("merged_y", rsp_ch.merged_y, w.m_c[1]);
            if (rsp_ch.merged_z !== w.m_c[2]) report("merged_z", rsp_ch.merged_z, w.m_c[2]);
            if (rsp_ch.merged_radius !== w.m_r)
               report("merged_radius", rsp_ch.merged_radius, w.m_r);
            if (rsp_ch.growth !== w.growth) report("growth", rsp_ch.growth, w.growth);
            if (rsp_ch.overlap !== w.overlap) report("overlap", rsp_ch.overlap, w.overlap);
            if (rsp_ch.enclosed !== w.enclosed) report("enclosed", rsp_ch.enclosed, w.enclosed);
         end
      end
   end

   // Watchdog: too many cycles without any accepted word ends the run.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

endmodule
